[rtl/tmr_pkg.sv]
// tmr_pkg: shared constants, event codes and state type for the traffic rate meter.
// No dependencies; used by tmr_front, tmr_div, tmr_back and traffic_rate_meter_core.
`default_nettype none

package tmr_pkg;

    // default counter widths and queue depth
    localparam int BYTE_COUNTER_BITS_DEF = 48;
    localparam int OP_COUNTER_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF       = 4;

    // fixed field widths
    localparam int MODE_W    = 3;
    localparam int BC_W      = 32;
    localparam int MS_W      = 16;
    localparam int CONN_W    = 16;
    localparam int RATE_W    = 58;
    localparam int OP_RATE_W = 42;
    localparam int SCALE_W   = 10;

    // rates are per second, elapsed time is in ms
    localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;

    // event codes on the mode field
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd4;

    // rate slots, in publish order
    localparam logic [1:0] SLOT_RD_BYTES = 2'd0;
    localparam logic [1:0] SLOT_WR_BYTES = 2'd1;
    localparam logic [1:0] SLOT_RD_OPS   = 2'd2;
    localparam logic [1:0] SLOT_WR_OPS   = 2'd3;

    // back-end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_EMIT
    } t_back_state;

endpackage

`default_nettype wire

[rtl/tmr_fifo.sv]
// tmr_fifo: small flip-flop queue between the event front end and the rate back end.
// Depends on nothing but its parameters.
`default_nettype none

module tmr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers wrap at the last entry, so any depth works
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == (AW+1)'(DEPTH)) |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

[rtl/tmr_front.sv]
// tmr_front: takes event words, keeps connection and traffic counters, snapshots on nonzero ticks.
// Uses tmr_pkg; feeds tmr_fifo.
`default_nettype none

module tmr_front #(
    parameter int BYTE_COUNTER_BITS = tmr_pkg::BYTE_COUNTER_BITS_DEF,
    parameter int OP_COUNTER_BITS   = tmr_pkg::OP_COUNTER_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [tmr_pkg::MODE_W-1:0]          i_mode,
    input  wire logic [tmr_pkg::BC_W-1:0]            i_byte_count,
    input  wire logic [tmr_pkg::MS_W-1:0]            i_elapsed_ms,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output logic [tmr_pkg::CONN_W-1:0]               o_conn,
    output logic                                     o_tick,
    output logic [tmr_pkg::MS_W-1:0]                 o_ms,
    output logic [BYTE_COUNTER_BITS-1:0]             o_d_rd_bytes,
    output logic [BYTE_COUNTER_BITS-1:0]             o_d_wr_bytes,
    output logic [OP_COUNTER_BITS-1:0]               o_d_rd_ops,
    output logic [OP_COUNTER_BITS-1:0]               o_d_wr_ops
);

    localparam int BW = BYTE_COUNTER_BITS;
    localparam int OW = OP_COUNTER_BITS;

    logic [tmr_pkg::CONN_W-1:0] r_conn, n_conn;
    logic [BW-1:0] r_rd_bytes, n_rd_bytes, r_wr_bytes, n_wr_bytes;
    logic [OW-1:0] r_rd_ops, n_rd_ops, r_wr_ops, n_wr_ops;
    logic [BW-1:0] r_snap_rd_bytes, r_snap_wr_bytes;
    logic [OW-1:0] r_snap_rd_ops, r_snap_wr_ops;
    logic          accept;
    logic          tick;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign tick    = (i_mode == tmr_pkg::MODE_TICK) && (i_elapsed_ms != '0);

    // counter updates per event
    always_comb begin
        n_conn     = r_conn;
        n_rd_bytes = r_rd_bytes;
        n_wr_bytes = r_wr_bytes;
        n_rd_ops   = r_rd_ops;
        n_wr_ops   = r_wr_ops;
        case (i_mode)
            tmr_pkg::MODE_OPEN:  n_conn = r_conn + 1'b1;
            tmr_pkg::MODE_CLOSE: n_conn = r_conn - 1'b1;
            tmr_pkg::MODE_READ: begin
                n_rd_ops   = r_rd_ops + 1'b1;
                n_rd_bytes = r_rd_bytes + BW'(i_byte_count);
            end
            tmr_pkg::MODE_WRITE: begin
                n_wr_ops   = r_wr_ops + 1'b1;
                n_wr_bytes = r_wr_bytes + BW'(i_byte_count);
            end
            default: ;
        endcase
    end

    // queue word: counts after the event, deltas since the last snapshot
    assign o_push       = accept;
    assign o_conn       = n_conn;
    assign o_tick       = tick;
    assign o_ms         = i_elapsed_ms;
    assign o_d_rd_bytes = r_rd_bytes - r_snap_rd_bytes;
    assign o_d_wr_bytes = r_wr_bytes - r_snap_wr_bytes;
    assign o_d_rd_ops   = r_rd_ops - r_snap_rd_ops;
    assign o_d_wr_ops   = r_wr_ops - r_snap_wr_ops;

    // counters and snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn          <= '0;
            r_rd_bytes      <= '0;
            r_wr_bytes      <= '0;
            r_rd_ops        <= '0;
            r_wr_ops        <= '0;
            r_snap_rd_bytes <= '0;
            r_snap_wr_bytes <= '0;
            r_snap_rd_ops   <= '0;
            r_snap_wr_ops   <= '0;
        end else if (accept) begin
            r_conn     <= n_conn;
            r_rd_bytes <= n_rd_bytes;
            r_wr_bytes <= n_wr_bytes;
            r_rd_ops   <= n_rd_ops;
            r_wr_ops   <= n_wr_ops;
            if (tick) begin
                r_snap_rd_bytes <= r_rd_bytes;
                r_snap_wr_bytes <= r_wr_bytes;
                r_snap_rd_ops   <= r_rd_ops;
                r_snap_wr_ops   <= r_wr_ops;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tmr_div.sv]
// tmr_div: restoring divider, one quotient bit per cycle, 16-bit divisor.
// Uses tmr_pkg for the divisor width.
`default_nettype none

module tmr_div #(
    parameter int NUM_W = 58
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [NUM_W-1:0]           i_numer,
    input  wire logic [tmr_pkg::MS_W-1:0]   i_denom,
    output logic                            o_done,
    output logic [NUM_W-1:0]                o_quot
);

    localparam int DW = tmr_pkg::MS_W;
    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] r_work;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;
    logic             ge;

    // one restoring step
    assign rem_sh  = {r_rem, r_work[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_done = r_done;
    assign o_quot = r_work;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_numer;
            r_rem  <= '0;
            r_den  <= i_denom;
        end else if (r_busy) begin
            r_work <= {r_work[NUM_W-2:0], ge};
            r_rem  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_done)
        else $error("divider restarted while running");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

[rtl/tmr_back.sv]
// tmr_back: drains queued events, sequences the shared divider on ticks, drives the output word.
// Uses tmr_pkg; paired with tmr_div and tmr_fifo in the top level.
`default_nettype none

module tmr_back #(
    parameter int BYTE_COUNTER_BITS = tmr_pkg::BYTE_COUNTER_BITS_DEF,
    parameter int OP_COUNTER_BITS   = tmr_pkg::OP_COUNTER_BITS_DEF,
    parameter int NUM_W             = 58
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // queue side
    input  wire logic                             i_empty,
    output logic                                  o_pop,
    input  wire logic [tmr_pkg::CONN_W-1:0]       i_conn,
    input  wire logic                             i_tick,
    input  wire logic [tmr_pkg::MS_W-1:0]         i_ms,
    input  wire logic [BYTE_COUNTER_BITS-1:0]     i_d_rd_bytes,
    input  wire logic [BYTE_COUNTER_BITS-1:0]     i_d_wr_bytes,
    input  wire logic [OP_COUNTER_BITS-1:0]       i_d_rd_ops,
    input  wire logic [OP_COUNTER_BITS-1:0]       i_d_wr_ops,
    // divider side
    output logic                                  o_div_start,
    output logic [NUM_W-1:0]                      o_div_numer,
    output logic [tmr_pkg::MS_W-1:0]              o_div_denom,
    input  wire logic                             i_div_done,
    input  wire logic [NUM_W-1:0]                 i_div_quot,
    // result channel
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [tmr_pkg::CONN_W-1:0]     o_connections,
    output logic [tmr_pkg::RATE_W-1:0]            o_read_byte_rate,
    output logic [tmr_pkg::RATE_W-1:0]            o_write_byte_rate,
    output logic [tmr_pkg::OP_RATE_W-1:0]         o_read_op_rate,
    output logic [tmr_pkg::OP_RATE_W-1:0]         o_write_op_rate,
    output logic                                  o_rates_updated
);

    localparam int BW = BYTE_COUNTER_BITS;
    localparam int OW = OP_COUNTER_BITS;
    localparam int RW = tmr_pkg::RATE_W;

    tmr_pkg::t_back_state r_state, n_state;

    logic [tmr_pkg::CONN_W-1:0] r_conn;
    logic [tmr_pkg::MS_W-1:0]   r_ms;
    logic [BW-1:0]              r_d_rd_bytes, r_d_wr_bytes;
    logic [OW-1:0]              r_d_rd_ops, r_d_wr_ops;
    logic [1:0]                 r_idx;
    logic [RW-1:0]              r_pub [4];

    logic                       r_out_valid;
    logic [tmr_pkg::CONN_W-1:0] r_out_conn;
    logic [RW-1:0]              r_out_rate [4];
    logic                       r_out_upd;

    logic                       out_free;
    logic                       latch_tick;
    logic                       load_plain;
    logic                       load_tick;
    logic                       store_rate;
    logic [NUM_W-1:0]           delta_sel;

    assign out_free = !r_out_valid || i_ready;

    // sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        latch_tick  = 1'b0;
        load_plain  = 1'b0;
        load_tick   = 1'b0;
        store_rate  = 1'b0;
        case (r_state)
            tmr_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    if (i_tick) begin
                        o_pop      = 1'b1;
                        latch_tick = 1'b1;
                        n_state    = tmr_pkg::ST_LOAD;
                    end else if (out_free) begin
                        o_pop      = 1'b1;
                        load_plain = 1'b1;
                    end
                end
            end
            tmr_pkg::ST_LOAD: begin
                o_div_start = 1'b1;
                n_state     = tmr_pkg::ST_WAIT;
            end
            tmr_pkg::ST_WAIT: begin
                if (i_div_done) begin
                    store_rate = 1'b1;
                    n_state    = (r_idx == tmr_pkg::SLOT_WR_OPS) ? tmr_pkg::ST_EMIT
                                                                : tmr_pkg::ST_LOAD;
                end
            end
            tmr_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_tick = 1'b1;
                    n_state   = tmr_pkg::ST_IDLE;
                end
            end
            default: n_state = tmr_pkg::ST_IDLE;
        endcase
    end

    // pick the delta for the current slot and scale to per-second
    always_comb begin
        case (r_idx)
            tmr_pkg::SLOT_RD_BYTES: delta_sel = NUM_W'(r_d_rd_bytes);
            tmr_pkg::SLOT_WR_BYTES: delta_sel = NUM_W'(r_d_wr_bytes);
            tmr_pkg::SLOT_RD_OPS:   delta_sel = NUM_W'(r_d_rd_ops);
            default:                delta_sel = NUM_W'(r_d_wr_ops);
        endcase
    end

    assign o_div_numer = delta_sel * NUM_W'(tmr_pkg::RATE_SCALE);
    assign o_div_denom = r_ms;

    // state, slot index and published rates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmr_pkg::ST_IDLE;
            r_idx   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_pub[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (latch_tick) begin
                r_idx <= '0;
            end else if (store_rate) begin
                r_pub[r_idx] <= RW'(i_div_quot);
                r_idx        <= r_idx + 1'b1;
            end
        end
    end

    // working copy of a tick word
    always_ff @(posedge i_clk) begin
        if (latch_tick) begin
            r_conn       <= i_conn;
            r_ms         <= i_ms;
            r_d_rd_bytes <= i_d_rd_bytes;
            r_d_wr_bytes <= i_d_wr_bytes;
            r_d_rd_ops   <= i_d_rd_ops;
            r_d_wr_ops   <= i_d_wr_ops;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_plain || load_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_plain) begin
            r_out_conn <= i_conn;
            r_out_upd  <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_out_rate[k] <= r_pub[k];
            end
        end else if (load_tick) begin
            r_out_conn <= r_conn;
            r_out_upd  <= 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_out_rate[k] <= r_pub[k];
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_connections     = r_out_conn;
    assign o_read_byte_rate  = r_out_rate[tmr_pkg::SLOT_RD_BYTES];
    assign o_write_byte_rate = r_out_rate[tmr_pkg::SLOT_WR_BYTES];
    assign o_read_op_rate    = r_out_rate[tmr_pkg::SLOT_RD_OPS][tmr_pkg::OP_RATE_W-1:0];
    assign o_write_op_rate   = r_out_rate[tmr_pkg::SLOT_WR_OPS][tmr_pkg::OP_RATE_W-1:0];
    assign o_rates_updated   = r_out_upd;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> r_state == tmr_pkg::ST_WAIT)
        else $error("divider result outside wait state");
    a_emit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmr_pkg::ST_EMIT && out_free) |=> o_valid && o_rates_updated)
        else $error("tick result not presented as an update");
`endif

endmodule

`default_nettype wire

[rtl/traffic_rate_meter_core.sv]
// traffic_rate_meter_core: top level of the I/O traffic rate meter.
// Uses tmr_pkg; instantiates tmr_front, tmr_fifo, tmr_div and tmr_back.
//
//   channel  handshake          payload
//   in       i_valid / o_ready  i_mode, i_byte_count, i_elapsed_ms
//   out      o_valid / i_ready  o_connections, o_*_rate, o_rates_updated
//
// Open, close, read, write and zero ticks: one word per cycle while the queue is not full;
// each is queued, then loaded into the output register. A nonzero tick holds the back end
// while the bit-serial divider, shared by the four rates, runs; NUM_W = max counter bits + 10.
// The front keeps taking words during a tick until the queue (QUEUE_DEPTH words) fills.
// Synchronous active-low reset clears counters, snapshot, published rates and the queue.
`default_nettype none

module traffic_rate_meter_core #(
    parameter int BYTE_COUNTER_BITS = tmr_pkg::BYTE_COUNTER_BITS_DEF,
    parameter int OP_COUNTER_BITS   = tmr_pkg::OP_COUNTER_BITS_DEF,
    parameter int QUEUE_DEPTH       = tmr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [tmr_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [tmr_pkg::BC_W-1:0]          i_byte_count,
    input  wire logic [tmr_pkg::MS_W-1:0]          i_elapsed_ms,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [tmr_pkg::CONN_W-1:0]      o_connections,
    output logic [tmr_pkg::RATE_W-1:0]             o_read_byte_rate,
    output logic [tmr_pkg::RATE_W-1:0]             o_write_byte_rate,
    output logic [tmr_pkg::OP_RATE_W-1:0]          o_read_op_rate,
    output logic [tmr_pkg::OP_RATE_W-1:0]          o_write_op_rate,
    output logic                                   o_rates_updated
);

    localparam int BW    = BYTE_COUNTER_BITS;
    localparam int OW    = OP_COUNTER_BITS;
    localparam int MAXW  = (BW > OW) ? BW : OW;
    localparam int NUM_W = MAXW + tmr_pkg::SCALE_W;
    localparam int EW    = tmr_pkg::CONN_W + 1 + tmr_pkg::MS_W + 2 * BW + 2 * OW;

    // front to queue
    logic                       push;
    logic                       full;
    logic [tmr_pkg::CONN_W-1:0] f_conn;
    logic                       f_tick;
    logic [tmr_pkg::MS_W-1:0]   f_ms;
    logic [BW-1:0]              f_d_rd_bytes, f_d_wr_bytes;
    logic [OW-1:0]              f_d_rd_ops, f_d_wr_ops;
    logic [EW-1:0]              q_wdata;

    // queue to back
    logic                       pop;
    logic                       empty;
    logic [EW-1:0]              q_rdata;
    logic [tmr_pkg::CONN_W-1:0] b_conn;
    logic                       b_tick;
    logic [tmr_pkg::MS_W-1:0]   b_ms;
    logic [BW-1:0]              b_d_rd_bytes, b_d_wr_bytes;
    logic [OW-1:0]              b_d_rd_ops, b_d_wr_ops;

    // back to divider
    logic                       div_start;
    logic [NUM_W-1:0]           div_numer;
    logic [tmr_pkg::MS_W-1:0]   div_denom;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quot;

    tmr_front #(
        .BYTE_COUNTER_BITS (BW),
        .OP_COUNTER_BITS   (OW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_byte_count (i_byte_count),
        .i_elapsed_ms (i_elapsed_ms),
        .i_full       (full),
        .o_push       (push),
        .o_conn       (f_conn),
        .o_tick       (f_tick),
        .o_ms         (f_ms),
        .o_d_rd_bytes (f_d_rd_bytes),
        .o_d_wr_bytes (f_d_wr_bytes),
        .o_d_rd_ops   (f_d_rd_ops),
        .o_d_wr_ops   (f_d_wr_ops)
    );

    // queue word layout
    assign q_wdata = {f_conn, f_tick, f_ms, f_d_rd_bytes, f_d_wr_bytes, f_d_rd_ops, f_d_wr_ops};
    assign {b_conn, b_tick, b_ms, b_d_rd_bytes, b_d_wr_bytes, b_d_rd_ops, b_d_wr_ops} = q_rdata;

    tmr_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (full),
        .o_empty (empty)
    );

    tmr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tmr_back #(
        .BYTE_COUNTER_BITS (BW),
        .OP_COUNTER_BITS   (OW),
        .NUM_W             (NUM_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .o_pop             (pop),
        .i_conn            (b_conn),
        .i_tick            (b_tick),
        .i_ms              (b_ms),
        .i_d_rd_bytes      (b_d_rd_bytes),
        .i_d_wr_bytes      (b_d_wr_bytes),
        .i_d_rd_ops        (b_d_rd_ops),
        .i_d_wr_ops        (b_d_wr_ops),
        .o_div_start       (div_start),
        .o_div_numer       (div_numer),
        .o_div_denom       (div_denom),
        .i_div_done        (div_done),
        .i_div_quot        (div_quot),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_connections     (o_connections),
        .o_read_byte_rate  (o_read_byte_rate),
        .o_write_byte_rate (o_write_byte_rate),
        .o_read_op_rate    (o_read_op_rate),
        .o_write_op_rate   (o_write_op_rate),
        .o_rates_updated   (o_rates_updated)
    );

endmodule

`default_nettype wire

[verif/tb_traffic_rate_meter_core.sv]
// tb_traffic_rate_meter_core: self-checking bench for the traffic rate meter core.
// Depends on rtl/tmr_pkg.sv and rtl/traffic_rate_meter_core.sv; predicts each result word
// from its own copy of the counters, snapshot and published rates.
`default_nettype none

module tb_traffic_rate_meter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W    = tmr_pkg::BYTE_COUNTER_BITS_DEF;
    localparam int OPS_W     = tmr_pkg::OP_COUNTER_BITS_DEF;
    localparam int MODE_BITS = tmr_pkg::MODE_W;
    localparam int MS_BITS   = tmr_pkg::MS_W;

    // mode codes the core has no use for
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_EVENTS = 1230;
    localparam int HOLD_AT       = 1000;  // results seen before the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct {
        logic [MODE_BITS-1:0]        mode;
        logic [tmr_pkg::BC_W-1:0]    bytes;
        logic [MS_BITS-1:0]          ms;
        int unsigned                 idle;
    } t_event;

    typedef struct {
        logic signed [tmr_pkg::CONN_W-1:0] conns;
        logic [tmr_pkg::RATE_W-1:0]        rd_bps;
        logic [tmr_pkg::RATE_W-1:0]        wr_bps;
        logic [tmr_pkg::OP_RATE_W-1:0]     rd_ops;
        logic [tmr_pkg::OP_RATE_W-1:0]     wr_ops;
        logic                              updated;
    } t_reading;

    // DUT signals
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [MODE_BITS-1:0]              i_mode = '0;
    logic [tmr_pkg::BC_W-1:0]          i_byte_count = '0;
    logic [MS_BITS-1:0]                i_elapsed_ms = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [tmr_pkg::CONN_W-1:0] o_connections;
    logic [tmr_pkg::RATE_W-1:0]        o_read_byte_rate;
    logic [tmr_pkg::RATE_W-1:0]        o_write_byte_rate;
    logic [tmr_pkg::OP_RATE_W-1:0]     o_read_op_rate;
    logic [tmr_pkg::OP_RATE_W-1:0]     o_write_op_rate;
    logic                              o_rates_updated;

    traffic_rate_meter_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_byte_count      (i_byte_count),
        .i_elapsed_ms      (i_elapsed_ms),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_connections     (o_connections),
        .o_read_byte_rate  (o_read_byte_rate),
        .o_write_byte_rate (o_write_byte_rate),
        .o_read_op_rate    (o_read_op_rate),
        .o_write_op_rate   (o_write_op_rate),
        .o_rates_updated   (o_rates_updated)
    );

    // clock and reset
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // predictor state
    logic [tmr_pkg::CONN_W-1:0] conn_count    = '0;
    logic [BYTE_W-1:0]          rd_bytes      = '0;
    logic [BYTE_W-1:0]          wr_bytes      = '0;
    logic [OPS_W-1:0]           rd_ops        = '0;
    logic [OPS_W-1:0]           wr_ops        = '0;
    logic [BYTE_W-1:0]          snap_rd_bytes = '0;
    logic [BYTE_W-1:0]          snap_wr_bytes = '0;
    logic [OPS_W-1:0]           snap_rd_ops   = '0;
    logic [OPS_W-1:0]           snap_wr_ops   = '0;
    logic [tmr_pkg::RATE_W-1:0] pub_rd_bps    = '0;
    logic [tmr_pkg::RATE_W-1:0] pub_wr_bps    = '0;
    logic [tmr_pkg::RATE_W-1:0] pub_rd_ops    = '0;
    logic [tmr_pkg::RATE_W-1:0] pub_wr_ops    = '0;

    t_event   event_backlog[$];
    t_reading pending_readings[$];
    t_event   cur_ev = '{mode: '0, bytes: '0, ms: '0, idle: 0};

    int unsigned run_budget   = 5000 + HOLD_CYCLES;
    int          events_sent  = 0;
    int          results_seen = 0;
    int          updates_seen = 0;
    int          fail_count   = 0;

    // floor(1000 * delta / ms); delta is at most 48 bits, so 64 bits never overflow
    function automatic logic [tmr_pkg::RATE_W-1:0] per_second(input logic [63:0] delta,
                                                              input logic [MS_BITS-1:0] ms);
        logic [63:0] prod;
        logic [63:0] quo;
        prod = delta * 64'(tmr_pkg::RATE_SCALE);
        quo  = prod / 64'(ms);
        return quo[tmr_pkg::RATE_W-1:0];
    endfunction

    // advance the predicted meter by one event and return the reading it shows
    function automatic t_reading meter_after_event(input t_event ev);
        t_reading          r;
        logic [BYTE_W-1:0] d_rd_bytes;
        logic [BYTE_W-1:0] d_wr_bytes;
        logic [OPS_W-1:0]  d_rd_ops;
        logic [OPS_W-1:0]  d_wr_ops;
        r.updated = 1'b0;
        case (ev.mode)
            tmr_pkg::MODE_OPEN:  conn_count = conn_count + 1'b1;
            tmr_pkg::MODE_CLOSE: conn_count = conn_count - 1'b1;
            tmr_pkg::MODE_READ: begin
                rd_ops   = rd_ops + 1'b1;
                rd_bytes = rd_bytes + BYTE_W'(ev.bytes);
            end
            tmr_pkg::MODE_WRITE: begin
                wr_ops   = wr_ops + 1'b1;
                wr_bytes = wr_bytes + BYTE_W'(ev.bytes);
            end
            tmr_pkg::MODE_TICK: begin
                if (ev.ms != '0) begin
                    // deltas wrap at the counter width
                    d_rd_bytes    = rd_bytes - snap_rd_bytes;
                    d_wr_bytes    = wr_bytes - snap_wr_bytes;
                    d_rd_ops      = rd_ops - snap_rd_ops;
                    d_wr_ops      = wr_ops - snap_wr_ops;
                    pub_rd_bps    = per_second(64'(d_rd_bytes), ev.ms);
                    pub_wr_bps    = per_second(64'(d_wr_bytes), ev.ms);
                    pub_rd_ops    = per_second(64'(d_rd_ops), ev.ms);
                    pub_wr_ops    = per_second(64'(d_wr_ops), ev.ms);
                    snap_rd_bytes = rd_bytes;
                    snap_wr_bytes = wr_bytes;
                    snap_rd_ops   = rd_ops;
                    snap_wr_ops   = wr_ops;
                    r.updated     = 1'b1;
                end
            end
            default: ;
        endcase
        r.conns  = conn_count;
        r.rd_bps = pub_rd_bps;
        r.wr_bps = pub_wr_bps;
        r.rd_ops = pub_rd_ops[tmr_pkg::OP_RATE_W-1:0];
        r.wr_ops = pub_wr_ops[tmr_pkg::OP_RATE_W-1:0];
        return r;
    endfunction

    // queue one event and grow the cycle budget by its worst case
    task automatic push_event(input logic [MODE_BITS-1:0] mode,
                              input logic [tmr_pkg::BC_W-1:0] bytes,
                              input logic [MS_BITS-1:0] ms, input int unsigned idle);
        t_event ev;
        ev.mode  = mode;
        ev.bytes = bytes;
        ev.ms    = ms;
        ev.idle  = idle;
        event_backlog.push_back(ev);
        run_budget += 4 * (idle + 8 + ((mode == tmr_pkg::MODE_TICK && ms != '0) ? 250 : 4));
    endtask

    // driver: one event word at a time, idle gap drawn per word
    bit          nxt_valid;
    int unsigned idle_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                pending_readings.push_back(meter_after_event(cur_ev));
                idle_left = cur_ev.idle;
                events_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && event_backlog.size() > 0) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else begin
                    cur_ev    = event_backlog.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            i_valid      <= nxt_valid;
            i_mode       <= cur_ev.mode;
            i_byte_count <= cur_ev.bytes;
            i_elapsed_ms <= cur_ev.ms;
        end
    end

    // monitor: compare each result word with the oldest predicted reading
    int unsigned stall_left = 0;
    bit          hold_done  = 1'b0;

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("result word with no event pending");
                    fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_connections !== want.conns) begin
                        $error("connections: expected %0d, got %0d", want.conns, o_connections);
                        fail_count++;
                    end
                    if (o_read_byte_rate !== want.rd_bps) begin
                        $error("read_byte_rate: expected %0d, got %0d",
                               want.rd_bps, o_read_byte_rate);
                        fail_count++;
                    end
                    if (o_write_byte_rate !== want.wr_bps) begin
                        $error("write_byte_rate: expected %0d, got %0d",
                               want.wr_bps, o_write_byte_rate);
                        fail_count++;
                    end
                    if (o_read_op_rate !== want.rd_ops) begin
                        $error("read_op_rate: expected %0d, got %0d",
                               want.rd_ops, o_read_op_rate);
                        fail_count++;
                    end
                    if (o_write_op_rate !== want.wr_ops) begin
                        $error("write_op_rate: expected %0d, got %0d",
                               want.wr_ops, o_write_op_rate);
                        fail_count++;
                    end
                    if (o_rates_updated !== want.updated) begin
                        $error("rates_updated: expected %0d, got %0d",
                               want.updated, o_rates_updated);
                        fail_count++;
                    end
                end
                results_seen++;
                if (o_rates_updated) updates_seen++;
                // every fourth window of 256 words the receiver draws no random stall
                stall_left = ((results_seen / 256) % 4 == 3) ? 0 : $urandom_range(6, 0);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            // one long hold-off so the core backs up and drops o_ready
            if (!hold_done && results_seen >= HOLD_AT) begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1'b1;
            end
            i_ready <= (stall_left == 0);
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned              idle;
        int                       pick;
        logic [tmr_pkg::BC_W-1:0] nbytes;
        logic [MS_BITS-1:0]       nms;
        logic [MODE_BITS-1:0]     m;

        // directed: connection wrap below zero, byte extremes, tick extremes, spare modes
        push_event(tmr_pkg::MODE_CLOSE, '0, '0, 0);
        push_event(tmr_pkg::MODE_OPEN, '0, '0, 1);
        push_event(tmr_pkg::MODE_OPEN, '1, '1, 0);
        push_event(tmr_pkg::MODE_READ, '0, '0, 2);
        push_event(tmr_pkg::MODE_READ, '1, '0, 0);
        push_event(tmr_pkg::MODE_WRITE, '1, '1, 0);
        push_event(tmr_pkg::MODE_WRITE, '0, '0, 3);
        push_event(tmr_pkg::MODE_TICK, '1, '0, 0);      // zero tick: nothing moves
        push_event(tmr_pkg::MODE_TICK, '0, 16'd1, 0);   // shortest tick, biggest rates
        for (int s = MODE_SPARE_LO; s <= MODE_SPARE_HI; s++) begin
            push_event(MODE_BITS'(s), $urandom, MS_BITS'($urandom), 0);
        end
        push_event(tmr_pkg::MODE_READ, 32'h1234_5678, '0, 0);
        push_event(tmr_pkg::MODE_WRITE, $urandom, '0, 1);
        push_event(tmr_pkg::MODE_TICK, '0, '1, 0);      // longest tick
        push_event(tmr_pkg::MODE_TICK, '0, '1, 0);      // no traffic since, rates drop to 0
        push_event(tmr_pkg::MODE_READ, '1, '0, 0);
        push_event(tmr_pkg::MODE_WRITE, 32'd7, '0, 0);
        push_event(tmr_pkg::MODE_TICK, '0, 16'd3, 0);   // remainder in the division
        push_event(tmr_pkg::MODE_TICK, '0, '0, 4);

        // random events with random content
        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            idle = ((i / 100) % 3 == 2) ? 0 : $urandom_range(6, 0);
            case ($urandom_range(3, 0))
                0:       nbytes = $urandom;
                1:       nbytes = $urandom_range(255, 0);
                2:       nbytes = '1;
                default: nbytes = '0;
            endcase
            case ($urandom_range(4, 0))
                0:       nms = '0;
                1:       nms = 16'd1;
                2:       nms = MS_BITS'($urandom_range(1000, 1));
                3:       nms = MS_BITS'($urandom);
                default: nms = '1;
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 10)      m = tmr_pkg::MODE_OPEN;
            else if (pick < 20) m = tmr_pkg::MODE_CLOSE;
            else if (pick < 50) m = tmr_pkg::MODE_READ;
            else if (pick < 80) m = tmr_pkg::MODE_WRITE;
            else if (pick < 95) m = tmr_pkg::MODE_TICK;
            else                m = MODE_BITS'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            push_event(m, nbytes, nms, idle);
        end

        // wait for every word to go in and every reading to come back
        while (event_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d events driven, %0d results checked, %0d rate refreshes", events_sent,
                 results_seen, updates_seen);
        $display("covered: connection count below zero, spare modes, zero and extreme ticks, %s",
                 "long receiver hold");
        if (fail_count == 0) begin
            $display("traffic_rate_meter_core: match");
        end else begin
            $display("traffic_rate_meter_core: mismatch");
        end
        $finish;
    end

    // timeout: budget is filled in at time zero, read after the first edge
    initial begin
        @(posedge i_clk);
        repeat (run_budget) @(posedge i_clk);
        $display("timeout after %0d cycles", run_budget);
        $display("traffic_rate_meter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
